>>> design/utf8_text_filter_defines.svh
// assertion macros for the utf8 text filter top module
// no dependencies; included by utf8_text_filter.sv, the only file that carries assertions
`ifndef UTF8_TEXT_FILTER_DEFINES_SVH
`define UTF8_TEXT_FILTER_DEFINES_SVH

// antecedent in one cycle implies consequent in the next
`define U8TF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition holds at every edge outside reset
`define U8TF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

>>> design/u8tf_pkg.sv
// types, constants and the code point filter for the utf8 text filter
// no dependencies; imported by every module of the block
package u8tf_pkg;

   localparam int CpWidth = 21;

   localparam logic [7:0] AsciiMax      = 8'h7F;
   localparam logic [7:0] SpaceChar     = 8'h20;
   localparam logic [7:0] Lead2Mask     = 8'hE0;
   localparam logic [7:0] Lead2Code     = 8'hC0;
   localparam logic [7:0] Lead3Mask     = 8'hF0;
   localparam logic [7:0] Lead3Code     = 8'hE0;
   localparam logic [7:0] Lead4Mask     = 8'hF8;
   localparam logic [7:0] Lead4Code     = 8'hF0;
   localparam logic [7:0] ContMask      = 8'hC0;
   localparam logic [7:0] ContCode      = 8'h80;

   localparam logic [CpWidth-1:0] CtrlMax     = 21'h00001F;
   localparam logic [CpWidth-1:0] TabChar     = 21'h000009;
   localparam logic [CpWidth-1:0] LfChar      = 21'h00000A;
   localparam logic [CpWidth-1:0] CrChar      = 21'h00000D;
   localparam logic [CpWidth-1:0] PrivLow     = 21'h00E000;
   localparam logic [CpWidth-1:0] PrivHigh    = 21'h00F8FF;
   localparam logic [CpWidth-1:0] SpecLow     = 21'h00FFF0;
   localparam logic [CpWidth-1:0] SpecHigh    = 21'h00FFFF;

   localparam logic [1:0] SeenNone = 2'd0;
   localparam logic [1:0] SeenOne  = 2'd1;
   localparam logic [1:0] SeenMany = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_message;
   } req_type;

   typedef struct packed {
      logic [1:0]         pending;
      logic [CpWidth-1:0] code_point;
      logic               error_seen;
      logic [1:0]         bytes_seen;
      logic               first_space;
   } state_type;

   typedef struct packed {
      logic valid;
      logic body_invalid;
   } result_type;

   function automatic logic cp_rejected(input logic [CpWidth-1:0] cp);
      logic ctrl;
      logic priv;
      logic spec;
      ctrl = (cp <= CtrlMax) && (cp != TabChar) && (cp != LfChar) && (cp != CrChar);
      priv = (cp >= PrivLow) && (cp <= PrivHigh);
      spec = (cp >= SpecLow) && (cp <= SpecHigh);
      return ctrl || priv || spec;
   endfunction

endpackage

>>> design/u8tf_decode.sv
// one decode step: current state and one request to next state and verdict
// depends on u8tf_pkg
module u8tf_decode
   import u8tf_pkg::*;
(
   input  req_type    req,
   input  state_type  state,
   output state_type  state_next,
   output result_type result
);

   state_type step;
   logic      bad;

   always_comb begin
      step = state;
      if (state.bytes_seen == SeenNone) begin
         step.first_space = (req.data_byte == SpaceChar);
      end
      if (state.bytes_seen != SeenMany) begin
         step.bytes_seen = state.bytes_seen + 2'd1;
      end

      if (!state.error_seen) begin
         if (state.pending != 2'd0) begin
            if ((req.data_byte & ContMask) != ContCode) begin
               step.error_seen = 1'b1;
            end else begin
               step.code_point = {state.code_point[CpWidth-7:0], req.data_byte[5:0]};
               step.pending    = state.pending - 2'd1;
               if (step.pending == 2'd0 && cp_rejected(step.code_point)) begin
                  step.error_seen = 1'b1;
               end
            end
         end else if (req.data_byte <= AsciiMax) begin
            step.code_point = {{(CpWidth-8){1'b0}}, req.data_byte};
            step.error_seen = cp_rejected(step.code_point);
         end else if ((req.data_byte & Lead2Mask) == Lead2Code) begin
            step.code_point = {{(CpWidth-5){1'b0}}, req.data_byte[4:0]};
            step.pending    = 2'd1;
         end else if ((req.data_byte & Lead3Mask) == Lead3Code) begin
            step.code_point = {{(CpWidth-4){1'b0}}, req.data_byte[3:0]};
            step.pending    = 2'd2;
         end else if ((req.data_byte & Lead4Mask) == Lead4Code) begin
            step.code_point = {{(CpWidth-3){1'b0}}, req.data_byte[2:0]};
            step.pending    = 2'd3;
         end else begin
            step.error_seen = 1'b1;
         end
      end

      bad = step.error_seen || (step.pending != 2'd0)
         || ((step.bytes_seen == SeenOne) && step.first_space);

      if (req.empty_message) begin
         state_next          = '0;
         result.valid        = 1'b1;
         result.body_invalid = 1'b1;
      end else if (req.last_byte) begin
         state_next          = '0;
         result.valid        = 1'b1;
         result.body_invalid = bad;
      end else begin
         state_next          = step;
         result.valid        = 1'b0;
         result.body_invalid = 1'b0;
      end
   end

endmodule

>>> design/utf8_text_filter.sv
// utf8 text filter: checks message bodies for well-formed utf-8 and banned characters
// requests enter on req_*, verdicts leave on rsp_*, both valid/ready channels.
// each request carries one body byte, a last-byte flag and an empty-message flag.
// one verdict per message: rsp_body_invalid=1 on a bad body, given for the
// request that carries last_byte or empty_message; other requests give none.
// throughput: one request per cycle while the result register can take each verdict,
// set by the single decode step between the input register and the state register.
// a request taken on req_* loads the input register and is decoded from there;
// its verdict is loaded into the result register and shown on rsp_* once the
// result register is free.
// reset (synchronous, active high) empties both registers and clears the
// decode state, ready for the first byte of a new message.
// when the receiver stalls, the verdict holds in the result register; byte
// requests that give no verdict still flow, and req_ready drops only when
// a second verdict would need the occupied result register.
// depends on u8tf_pkg, u8tf_decode and utf8_text_filter_defines.svh
`include "utf8_text_filter_defines.svh"

module utf8_text_filter
   import u8tf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_empty_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_body_invalid
);

   logic       s1_valid_ff;
   req_type    s1_req_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result;
   logic       rsp_valid_ff;
   logic       rsp_body_invalid_ff;
   logic       out_free;
   logic       s1_fire;

   u8tf_decode u_decode (
      .req        (s1_req_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!result.valid || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_fire) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_fire && result.valid;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= '{data_byte: req_data_byte, last_byte: req_last_byte,
                        empty_message: req_empty_message};
      end
      if (s1_fire && result.valid) begin
         rsp_body_invalid_ff <= result.body_invalid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_body_invalid = rsp_body_invalid_ff;

   `U8TF_ASSERT_NEXT(a_clear_after_verdict, clock, reset,
      s1_fire && (s1_req_ff.last_byte || s1_req_ff.empty_message), state_ff == '0,
      "decode state not cleared after a verdict")

   `U8TF_ASSERT_NEXT(a_empty_is_invalid, clock, reset,
      s1_fire && s1_req_ff.empty_message, rsp_valid_ff && rsp_body_invalid_ff,
      "empty message did not give an invalid verdict")

   `U8TF_ASSERT_ALWAYS(a_seen_saturates, clock, reset,
      state_ff.bytes_seen != 2'd3,
      "byte count ran past saturation")

endmodule

>>> tb/sv/utf8_text_filter_tb.sv
// testbench for utf8_text_filter: directed and random message bodies, with and without random stalls
// an in-bench decoder predicts each verdict, which is checked in order against rsp_*
// depends on u8tf_pkg and the utf8_text_filter design files
module utf8_text_filter_tb;
   import u8tf_pkg::*;

   localparam int IdleLimit   = 2000;
   localparam int PhaseItems  = 267;
   localparam int SettleTicks = 4;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       req_empty_message;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_body_invalid;

   utf8_text_filter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_empty_message(req_empty_message),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_body_invalid (rsp_body_invalid)
   );

   // decoder state kept by the bench
   logic [1:0]         dec_pending;
   logic [CpWidth-1:0] dec_code_point;
   logic               dec_error;
   logic [1:0]         dec_seen;
   logic               dec_first_space;

   logic       expected_verdicts[$];
   logic [7:0] msg_bytes[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int requests_sent;
   int verdicts_checked;
   int verdicts_invalid;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic cp_banned(input logic [CpWidth-1:0] c);
      return ((c <= CtrlMax) && (c != TabChar) && (c != LfChar) && (c != CrChar))
         || ((c >= PrivLow) && (c <= PrivHigh))
         || ((c >= SpecLow) && (c <= SpecHigh));
   endfunction

   task automatic clear_decoder();
      dec_pending     = 2'd0;
      dec_code_point  = '0;
      dec_error       = 1'b0;
      dec_seen        = SeenNone;
      dec_first_space = 1'b0;
   endtask

   task automatic predict_verdict(input logic [7:0] b, input logic is_last,
                                  input logic is_empty);
      logic bad;
      if (is_empty) begin
         clear_decoder();
         expected_verdicts.push_back(1'b1);
      end else begin
         if (dec_seen == SeenNone)
            dec_first_space = (b == SpaceChar);
         if (dec_seen != SeenMany)
            dec_seen = dec_seen + 2'd1;
         if (!dec_error) begin
            if (dec_pending != 2'd0) begin
               if ((b & ContMask) != ContCode) begin
                  dec_error = 1'b1;
               end else begin
                  dec_code_point = {dec_code_point[CpWidth-7:0], b[5:0]};
                  dec_pending    = dec_pending - 2'd1;
                  if (dec_pending == 2'd0 && cp_banned(dec_code_point))
                     dec_error = 1'b1;
               end
            end else if (b <= AsciiMax) begin
               dec_code_point = {13'd0, b};
               if (cp_banned(dec_code_point))
                  dec_error = 1'b1;
            end else if ((b & Lead2Mask) == Lead2Code) begin
               dec_code_point = {16'd0, b[4:0]};
               dec_pending    = 2'd1;
            end else if ((b & Lead3Mask) == Lead3Code) begin
               dec_code_point = {17'd0, b[3:0]};
               dec_pending    = 2'd2;
            end else if ((b & Lead4Mask) == Lead4Code) begin
               dec_code_point = {18'd0, b[2:0]};
               dec_pending    = 2'd3;
            end else begin
               dec_error = 1'b1;
            end
         end
         if (is_last) begin
            bad = dec_error || (dec_pending != 2'd0)
               || (dec_seen == SeenOne && dec_first_space);
            expected_verdicts.push_back(bad);
            clear_decoder();
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic got, input logic want);
      $display("mismatch at %0t: %s got %0b want %0b", $time, what, got, want);
      mismatches++;
   endtask

   task automatic send_request(input logic [7:0] b, input logic is_last, input logic is_empty);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_last_byte     <= is_last;
      req_empty_message <= is_empty;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_verdict(b, is_last, is_empty);
      requests_sent++;
   endtask

   task automatic send_message();
      int i;
      for (i = 0; i < msg_bytes.size(); i++)
         send_request(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0);
      msg_bytes.delete();
   endtask

   task automatic add_code_point(input int nbytes, input logic [CpWidth-1:0] c);
      case (nbytes)
         1: msg_bytes.push_back({1'b0, c[6:0]});
         2: begin
            msg_bytes.push_back({3'b110, c[10:6]});
            msg_bytes.push_back({2'b10, c[5:0]});
         end
         3: begin
            msg_bytes.push_back({4'b1110, c[15:12]});
            msg_bytes.push_back({2'b10, c[11:6]});
            msg_bytes.push_back({2'b10, c[5:0]});
         end
         default: begin
            msg_bytes.push_back({5'b11110, c[20:18]});
            msg_bytes.push_back({2'b10, c[17:12]});
            msg_bytes.push_back({2'b10, c[11:6]});
            msg_bytes.push_back({2'b10, c[5:0]});
         end
      endcase
   endtask

   task automatic add_random_char();
      int pick;
      int sub;
      pick = $urandom_range(99, 0);
      if (pick < 35) begin
         add_code_point(1, CpWidth'($urandom_range(8'h7E, 8'h20)));
      end else if (pick < 40) begin
         add_code_point(1, ($urandom_range(3, 0) == 0) ? 21'h7F
                                                       : CpWidth'($urandom_range(31, 0)));
      end else if (pick < 55) begin
         add_code_point(2, CpWidth'($urandom_range(21'h7FF, 0)));
      end else if (pick < 70) begin
         sub = $urandom_range(2, 0);
         if (sub == 0)
            add_code_point(3, CpWidth'($urandom_range(21'hFFFF, 0)));
         else if (sub == 1)
            add_code_point(3, CpWidth'($urandom_range(21'hF900, 21'hDFFF)));
         else
            add_code_point(3, CpWidth'($urandom_range(21'hFFFF, 21'hFFE0)));
      end else if (pick < 82) begin
         add_code_point(4, CpWidth'($urandom_range(21'h1FFFFF, 0)));
      end else if (pick < 88) begin
         msg_bytes.push_back(8'($urandom_range(255, 0)));
      end else if (pick < 93) begin
         // lead followed by something that is not a continuation
         msg_bytes.push_back(8'($urandom_range(8'hF7, 8'hC0)));
         msg_bytes.push_back(($urandom_range(1, 0) == 0) ? 8'($urandom_range(8'h7F, 0))
                                                        : 8'($urandom_range(8'hFF, 8'hC0)));
      end else begin
         msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end
   endtask

   task automatic send_random_message();
      int kind;
      int n;
      int i;
      kind = $urandom_range(99, 0);
      if (kind < 4) begin
         msg_bytes.push_back(SpaceChar);
         send_message();
      end else if (kind < 8) begin
         send_request(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1);
      end else if (kind < 12) begin
         // abandoned body: bytes without a last one, then an empty message
         n = $urandom_range(3, 1);
         for (i = 0; i < n; i++)
            send_request(8'($urandom_range(255, 0)), 1'b0, 1'b0);
         send_request(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1);
      end else begin
         n = $urandom_range(4, 1);
         for (i = 0; i < n; i++)
            add_random_char();
         if (kind < 17) begin
            // body ends on a lead byte, sometimes followed by one continuation byte
            msg_bytes.push_back(8'($urandom_range(8'hF7, 8'hC0)));
            if ($urandom_range(1, 0) == 1)
               msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
         end
         send_message();
      end
   endtask

   task automatic wait_for_verdicts();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct = 19;
      recv_idle_pct = 73;
      send_request(8'hFF, 1'b1, 1'b1);
      msg_bytes = '{8'h20};
      send_message();
      msg_bytes = '{8'h41};
      send_message();
      msg_bytes = '{8'h09, 8'h0A, 8'h0D, 8'h7F};
      send_message();
      msg_bytes = '{8'h00};
      send_message();
      msg_bytes = '{8'hFF};
      send_message();
      msg_bytes = '{8'hC3, 8'hA9};
      send_message();
      msg_bytes = '{8'hEF, 8'hBF, 8'hBF};
      send_message();
      msg_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_message();
      msg_bytes = '{8'hC3, 8'h41};
      send_message();
      msg_bytes = '{8'hC3};
      send_message();
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      msg_bytes = '{8'h20, 8'h20};
      send_message();
      wait_for_verdicts();
   endtask

   task automatic test_random(input int send_pct, input int recv_pct);
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = requests_sent + PhaseItems;
      while (requests_sent < stop_at)
         send_random_message();
      wait_for_verdicts();
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("verdict with none expected", rsp_body_invalid, 1'bx);
         end else begin
            if (rsp_body_invalid !== expected_verdicts[0])
               report_mismatch("body_invalid", rsp_body_invalid, expected_verdicts[0]);
            verdicts_invalid += int'(expected_verdicts[0]);
            void'(expected_verdicts.pop_front());
         end
         verdicts_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = 8'h00;
      req_last_byte     = 1'b0;
      req_empty_message = 1'b0;
      rsp_ready         = 1'b0;
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      mismatches        = 0;
      requests_sent     = 0;
      verdicts_checked  = 0;
      verdicts_invalid  = 0;
      quiet_cycles      = 0;
      clear_decoder();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(19, 73);
      test_random(73, 19);
      test_random(0, 0);

      $display("covered %0d requests and %0d verdicts, %0d of them invalid bodies",
               requests_sent, verdicts_checked, verdicts_invalid);
      $display("stall mixes: sender-heavy, receiver-heavy and none; %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> utf8_text_filter.f
+incdir+design
design/u8tf_pkg.sv
design/u8tf_decode.sv
design/utf8_text_filter.sv
tb/sv/utf8_text_filter_tb.sv
